// ----- rtl/median_gated_gradient_accumulator_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the median gated gradient accumulator
// ---------------------------------------------------------------------------
`ifndef MEDIAN_GATED_GRADIENT_ACCUMULATOR_ASSERT_SVH
`define MEDIAN_GATED_GRADIENT_ACCUMULATOR_ASSERT_SVH

// Invariant checked on every clock edge out of reset.
`define MGGA_CHK(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("mgga invariant violated");

// Same-cycle implication.
`define MGGA_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mgga implication violated");

// Next-cycle implication.
`define MGGA_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mgga sequence violated");

`endif

// ----- rtl/mgga_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mgga_pkg
// Shared types, codes and arithmetic helpers of the gradient accumulator.
// ---------------------------------------------------------------------------
package mgga_pkg;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam int GAIN_W   = 32;
    localparam int SUM_W    = 48;
    localparam int STEP_W   = 40;
    localparam int CNT_W    = 16;
    localparam int LSQ_W    = 64;
    localparam int THR_W    = 76;   // 2500 * median fits in 76 bits
    localparam int ACC_W    = 13;
    localparam int IN_DW    = 112;
    localparam int OUT_DW   = 240;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'h0100_0000;

    typedef struct packed {
        logic [LSQ_W-1:0]  lensq;
        logic              usable;
        logic [11:0]       vertex;
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
    } t_elem;

    typedef struct packed {
        logic [CNT_W-1:0]        cnt;
        logic signed [SUM_W-1:0] sz;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] sx;
    } t_field;

    localparam int ELEM_W  = $bits(t_elem);
    localparam int FIELD_W = $bits(t_field);

    // 2500 = 2^11 + 2^8 + 2^7 + 2^6 + 2^2, one term per step
    function automatic logic [3:0] f_gate_shift(input logic [2:0] step);
        logic [3:0] s;
        case (step)
            3'd0:    s = 4'd11;
            3'd1:    s = 4'd8;
            3'd2:    s = 4'd7;
            3'd3:    s = 4'd6;
            default: s = 4'd2;
        endcase
        return s;
    endfunction

    // -(p) rounded from Q24.40 to Q24.16: floor((-p + 2^23) / 2^24)
    function automatic logic signed [STEP_W-1:0] f_step(input logic signed [63:0] p);
        logic [63:0] t;
        t = ~p + 64'h0000_0000_0080_0001;
        return $signed(t[63:24]);
    endfunction

    function automatic logic signed [SUM_W-1:0] f_sat_add(
        input logic signed [SUM_W-1:0]  s,
        input logic signed [STEP_W-1:0] d
    );
        logic signed [SUM_W:0] r;
        r = {s[SUM_W-1], s} + {{(SUM_W+1-STEP_W){d[STEP_W-1]}}, d};
        if (r[SUM_W] != r[SUM_W-1]) begin
            return r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        return r[SUM_W-1:0];
    endfunction

endpackage

// ----- rtl/median_gated_gradient_accumulator.sv -----
`timescale 1ns / 1ps
// Path from accept to result valid: load S_LX, S_LY, S_LZ, S_LW; read S_RD; clear S_CLR over
// every vertex; all ops end in S_OUT. The last load of a batch adds, before S_OUT, 64 radix
// passes over the stored items through the element RAM read port (no passes without candidates),
// the gate threshold, then S_ARD and S_AGATE per item, and S_AMY to S_AWR per accepted item whose
// vertex is in range. One item at a time; s_tready rises in the same cycle the result register loads.
// Reset (synchronous, active low) clears the sum store one vertex at a time, s_tready low.
// ---------------------------------------------------------------------------
// median_gated_gradient_accumulator
// Batch store, radix median select and gated scatter-add into per-vertex sums.
// ---------------------------------------------------------------------------
`include "median_gated_gradient_accumulator_assert.svh"

module median_gated_gradient_accumulator #(
    parameter int MAX_ELEMENTS = 4096,
    parameter int MAX_VERTICES = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // disp_x, disp_y, disp_z, vertex_index, 4'b0
    input  logic [2:0]   s_tuser,   // op[1:0], non_finite
    input  logic         s_tlast,   // last_element
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [239:0] m_tdata,   // sum_x, sum_y, sum_z, contrib_count,
                                    // median_length_sq, accepted_count, 3'b0
    output logic         m_tuser    // done_res
);
    localparam int EW = $clog2(MAX_ELEMENTS);
    localparam int CW = EW + 1;
    localparam int VW = $clog2(MAX_VERTICES);

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_LX, S_LY, S_LZ, S_LW, S_RD, S_BSTART, S_PASS, S_THR,
        S_ARD, S_AGATE, S_AMY, S_AMZ, S_ADZ, S_AWR, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic r_boot, n_boot;
    logic [1:0] r_op, n_op;
    logic signed [31:0] r_x, n_x, r_y, n_y, r_z, n_z;
    logic r_usable, n_usable;
    logic [11:0] r_vertex, n_vertex;
    logic r_last, n_last;
    logic [VW-1:0] r_vaddr, n_vaddr;
    logic r_vok, n_vok;
    logic r_done, n_done;
    logic [CW-1:0] r_elem_cnt, n_elem_cnt, r_cand, n_cand, r_idx, n_idx;
    logic [CW-1:0] r_c, n_c, r_k, n_k;
    logic r_rvld, n_rvld;
    logic [63:0] r_prefix, n_prefix, r_mask, n_mask, r_acc_sq, n_acc_sq;
    logic [5:0] r_bit, n_bit;
    logic [mgga_pkg::THR_W-1:0] r_thr, n_thr;
    logic [2:0] r_tstep, n_tstep;
    logic [mgga_pkg::ACC_W-1:0] r_acc_cnt, n_acc_cnt, r_accd, n_accd;
    logic [63:0] r_med, n_med;
    logic signed [mgga_pkg::STEP_W-1:0] r_dx, n_dx, r_dy, n_dy, r_dz, n_dz;
    logic [VW-1:0] r_clr_idx, n_clr_idx;
    logic [31:0] r_gain, n_gain;
    logic r_mvalid, n_mvalid;
    logic [239:0] r_mdata, n_mdata;
    logic r_muser, n_muser;

    logic signed [32:0] w_ma, w_mb;
    logic signed [63:0] w_prod;
    logic w_ewe, w_fwe;
    logic [mgga_pkg::ELEM_W-1:0] w_ewdata, w_erdata;
    logic [mgga_pkg::FIELD_W-1:0] w_fwdata, w_frdata;
    logic [VW-1:0] w_fwaddr;
    mgga_pkg::t_elem w_erd, w_enew;
    mgga_pkg::t_field w_frd, w_fnew;
    logic [31:0] w_vext_in, w_vext_e;
    logic w_match;

    mgga_mul u_mul (.i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_p(w_prod));

    mgga_ram #(.WIDTH(mgga_pkg::ELEM_W), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
        .i_clk(i_clk), .i_we(w_ewe), .i_waddr(r_elem_cnt[EW-1:0]), .i_wdata(w_ewdata),
        .i_raddr(r_idx[EW-1:0]), .o_rdata(w_erdata)
    );

    mgga_ram #(.WIDTH(mgga_pkg::FIELD_W), .DEPTH(MAX_VERTICES)) u_field_ram (
        .i_clk(i_clk), .i_we(w_fwe), .i_waddr(w_fwaddr), .i_wdata(w_fwdata),
        .i_raddr(r_vaddr), .o_rdata(w_frdata)
    );

    assign w_erd     = mgga_pkg::t_elem'(w_erdata);
    assign w_frd     = mgga_pkg::t_field'(w_frdata);
    assign w_vext_in = 32'(s_tdata[107:96]);
    assign w_vext_e  = 32'(w_erd.vertex);
    assign w_match   = w_erd.usable && (w_erd.lensq != 64'd0)
                       && (((w_erd.lensq ^ r_prefix) & r_mask) == 64'd0)
                       && !w_erd.lensq[r_bit];

    // element record written at the end of a load
    always_comb begin
        w_enew        = '0;
        w_enew.x      = r_x;
        w_enew.y      = r_y;
        w_enew.z      = r_z;
        w_enew.vertex = r_vertex;
        w_enew.usable = r_usable;
        w_enew.lensq  = r_acc_sq + 64'(unsigned'(w_prod));
        w_ewdata      = w_enew;
        w_ewe         = (r_state == S_LW) && (r_elem_cnt < CW'(MAX_ELEMENTS));
    end

    // field update for an accepted item, or a zero write while clearing
    always_comb begin
        w_fnew    = w_frd;
        w_fnew.sx = mgga_pkg::f_sat_add(w_frd.sx, r_dx);
        w_fnew.sy = mgga_pkg::f_sat_add(w_frd.sy, r_dy);
        w_fnew.sz = mgga_pkg::f_sat_add(w_frd.sz, r_dz);
        if (((w_erd.x | w_erd.y | w_erd.z) != 32'd0) && (w_frd.cnt != 16'hFFFF)) begin
            w_fnew.cnt = w_frd.cnt + 16'd1;
        end
        w_fwe    = (r_state == S_CLR) || (r_state == S_AWR);
        w_fwaddr = (r_state == S_CLR) ? r_clr_idx : r_vaddr;
        w_fwdata = (r_state == S_CLR) ? '0 : w_fnew;
    end

    always_comb begin
        case (r_state)
            S_LX:    begin w_ma = {r_x[31], r_x}; w_mb = {r_x[31], r_x}; end
            S_LY:    begin w_ma = {r_y[31], r_y}; w_mb = {r_y[31], r_y}; end
            S_LZ:    begin w_ma = {r_z[31], r_z}; w_mb = {r_z[31], r_z}; end
            S_AGATE: begin w_ma = {w_erd.x[31], w_erd.x}; w_mb = $signed({1'b0, r_gain}); end
            S_AMY:   begin w_ma = {w_erd.y[31], w_erd.y}; w_mb = $signed({1'b0, r_gain}); end
            S_AMZ:   begin w_ma = {w_erd.z[31], w_erd.z}; w_mb = $signed({1'b0, r_gain}); end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
    end

    always_comb begin
        n_state = r_state;   n_boot = r_boot;     n_op = r_op;
        n_x = r_x;           n_y = r_y;           n_z = r_z;
        n_usable = r_usable; n_vertex = r_vertex; n_last = r_last;
        n_vaddr = r_vaddr;   n_vok = r_vok;       n_done = r_done;
        n_elem_cnt = r_elem_cnt; n_cand = r_cand; n_idx = r_idx;
        n_c = r_c;           n_k = r_k;           n_rvld = 1'b0;
        n_prefix = r_prefix; n_mask = r_mask;     n_acc_sq = r_acc_sq;
        n_bit = r_bit;       n_thr = r_thr;       n_tstep = r_tstep;
        n_acc_cnt = r_acc_cnt; n_accd = r_accd;   n_med = r_med;
        n_dx = r_dx;         n_dy = r_dy;         n_dz = r_dz;
        n_clr_idx = r_clr_idx;
        n_gain = i_cfg_we ? i_cfg_wdata : r_gain;
        n_mvalid = r_mvalid && !m_tready;
        n_mdata = r_mdata;   n_muser = r_muser;

        case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    n_op     = s_tuser[1:0];
                    n_x      = $signed(s_tdata[31:0]);
                    n_y      = $signed(s_tdata[63:32]);
                    n_z      = $signed(s_tdata[95:64]);
                    n_usable = !s_tuser[2];
                    n_vertex = s_tdata[107:96];
                    n_last   = s_tlast;
                    n_vaddr  = w_vext_in[VW-1:0];
                    n_vok    = w_vext_in < 32'(MAX_VERTICES);
                    n_done   = 1'b0;
                    case (s_tuser[1:0])
                        mgga_pkg::OP_CLEAR: begin
                            n_clr_idx = '0;
                            n_done    = 1'b1;
                            n_state   = S_CLR;
                        end
                        mgga_pkg::OP_LOAD: n_state = S_LX;
                        mgga_pkg::OP_READ: n_state = S_RD;
                        default:           n_state = S_OUT;
                    endcase
                end
            end
            S_CLR: begin
                n_clr_idx = r_clr_idx + VW'(1);
                if (r_clr_idx == VW'(MAX_VERTICES - 1)) begin
                    n_boot  = 1'b0;
                    n_state = r_boot ? S_IDLE : S_OUT;
                end
            end
            S_LX: n_state = S_LY;
            S_LY: begin
                n_acc_sq = 64'(unsigned'(w_prod));
                n_state  = S_LZ;
            end
            S_LZ: begin
                n_acc_sq = r_acc_sq + 64'(unsigned'(w_prod));
                n_state  = S_LW;
            end
            S_LW: begin
                if (w_ewe) begin
                    n_elem_cnt = r_elem_cnt + CW'(1);
                    if (r_usable && (w_enew.lensq != 64'd0)) begin
                        n_cand = r_cand + CW'(1);
                    end
                end
                n_state = r_last ? S_BSTART : S_OUT;
            end
            S_RD: n_state = S_OUT;
            S_BSTART: begin
                n_k      = r_cand >> 1;
                n_prefix = '0;
                n_mask   = '0;
                n_bit    = 6'd63;
                n_idx    = '0;
                n_c      = '0;
                n_thr    = '0;
                n_tstep  = '0;
                n_state  = (r_cand == '0) ? S_THR : S_PASS;
            end
            S_PASS: begin
                // one radix digit per pass: count candidates below on this bit
                if (r_idx < r_elem_cnt) begin
                    n_idx  = r_idx + CW'(1);
                    n_rvld = 1'b1;
                end
                if (r_rvld && w_match) begin
                    n_c = r_c + CW'(1);
                end
                if (!(r_idx < r_elem_cnt) && !r_rvld) begin
                    if (!(r_k < r_c)) begin
                        n_prefix = r_prefix | (64'd1 << r_bit);
                        n_k      = r_k - r_c;
                    end
                    n_mask = r_mask | (64'd1 << r_bit);
                    n_bit  = r_bit - 6'd1;
                    n_idx  = '0;
                    n_c    = '0;
                    if (r_bit == 6'd0) begin
                        n_state = S_THR;
                    end
                end
            end
            S_THR: begin
                n_thr   = r_thr + ({12'd0, r_prefix} << mgga_pkg::f_gate_shift(r_tstep));
                n_tstep = r_tstep + 3'd1;
                if (r_tstep == 3'd4) begin
                    n_idx     = '0;
                    n_acc_cnt = '0;
                    n_state   = S_ARD;
                end
            end
            S_ARD: begin
                if (r_idx < r_elem_cnt) begin
                    n_state = S_AGATE;
                end else begin
                    n_med      = r_prefix;
                    n_accd     = r_acc_cnt;
                    n_elem_cnt = '0;
                    n_cand     = '0;
                    n_done     = 1'b1;
                    n_state    = S_OUT;
                end
            end
            S_AGATE: begin
                n_state = S_ARD;
                n_idx   = r_idx + CW'(1);
                if (w_erd.usable && ({12'd0, w_erd.lensq} < r_thr)) begin
                    if (r_acc_cnt != '1) begin
                        n_acc_cnt = r_acc_cnt + mgga_pkg::ACC_W'(1);
                    end
                    if (w_vext_e < 32'(MAX_VERTICES)) begin
                        n_vaddr = w_vext_e[VW-1:0];
                        n_idx   = r_idx;
                        n_state = S_AMY;
                    end
                end
            end
            S_AMY: begin
                n_dx    = mgga_pkg::f_step(w_prod);
                n_state = S_AMZ;
            end
            S_AMZ: begin
                n_dy    = mgga_pkg::f_step(w_prod);
                n_state = S_ADZ;
            end
            S_ADZ: begin
                n_dz    = mgga_pkg::f_step(w_prod);
                n_state = S_AWR;
            end
            S_AWR: begin
                n_idx   = r_idx + CW'(1);
                n_state = S_ARD;
            end
            S_OUT: begin
                if (!r_mvalid || m_tready) begin
                    n_mvalid = 1'b1;
                    n_muser  = r_done;
                    n_mdata  = '0;
                    if ((r_op == mgga_pkg::OP_READ) && r_vok) begin
                        n_mdata[159:0] = w_frdata;
                    end
                    if ((r_op == mgga_pkg::OP_CLEAR) || (r_op == mgga_pkg::OP_LOAD)
                        || (r_op == mgga_pkg::OP_READ)) begin
                        n_mdata[223:160] = r_med;
                        n_mdata[236:224] = r_accd;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_boot     <= 1'b1;
            r_clr_idx  <= '0;
            r_elem_cnt <= '0;
            r_cand     <= '0;
            r_idx      <= '0;
            r_rvld     <= 1'b0;
            r_k        <= '0;
            r_med      <= '0;
            r_accd     <= '0;
            r_gain     <= mgga_pkg::GAIN_RESET;
            r_mvalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_boot     <= n_boot;
            r_clr_idx  <= n_clr_idx;
            r_elem_cnt <= n_elem_cnt;
            r_cand     <= n_cand;
            r_idx      <= n_idx;
            r_rvld     <= n_rvld;
            r_k        <= n_k;
            r_med      <= n_med;
            r_accd     <= n_accd;
            r_gain     <= n_gain;
            r_mvalid   <= n_mvalid;
        end
        r_op <= n_op;         r_x <= n_x;           r_y <= n_y;       r_z <= n_z;
        r_usable <= n_usable; r_vertex <= n_vertex; r_last <= n_last;
        r_vaddr <= n_vaddr;   r_vok <= n_vok;       r_done <= n_done;
        r_c <= n_c;           r_prefix <= n_prefix; r_mask <= n_mask;
        r_acc_sq <= n_acc_sq; r_bit <= n_bit;       r_thr <= n_thr;
        r_tstep <= n_tstep;   r_acc_cnt <= n_acc_cnt;
        r_dx <= n_dx;         r_dy <= n_dy;         r_dz <= n_dz;
        r_mdata <= n_mdata;   r_muser <= n_muser;
    end

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_mvalid;
    assign m_tdata  = r_mdata;
    assign m_tuser  = r_muser;

    `MGGA_CHK(a_cnt_range, r_elem_cnt <= CW'(MAX_ELEMENTS))
    `MGGA_CHK(a_cand_le_cnt, r_cand <= r_elem_cnt)
    `MGGA_IMP(a_rank_in_set, r_state == S_PASS, r_k < r_cand)
    `MGGA_NXT(a_wr_then_next, r_state == S_AWR, r_state == S_ARD)
endmodule

// ----- rtl/mgga_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mgga_ram
// Generic simple dual port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module mgga_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/mgga_mul.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mgga_mul
// Shared signed 33x33 multiplier with registered product.
// ---------------------------------------------------------------------------
module mgga_mul (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [63:0] o_p
);
    logic signed [65:0] w_full;
    logic signed [63:0] r_p;

    assign w_full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_p <= w_full[63:0];
    end

    assign o_p = r_p;
endmodule

// ----- tb/sv/median_gated_gradient_accumulator_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// median_gated_gradient_accumulator_test
// Self-checking bench: streams clear, load, read and no-op items into the block,
// predicts every result item from its own model of the batch store, median
// gate and saturating per-vertex sums, and compares each result field by field.
// ---------------------------------------------------------------------------
module median_gated_gradient_accumulator_test;

    localparam int  NUM_ELEM   = 4096;
    localparam int  NUM_VERT   = 4096;
    localparam int  CYCLE_CAP  = 4_000_000;
    localparam logic [1:0] OP_NOP = 2'd3;

    typedef struct {
        logic [1:0]         op;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               nf;
        logic [11:0]        vi;
        logic               last;
    } t_vec_item;

    typedef struct {
        logic [47:0] sx;
        logic [47:0] sy;
        logic [47:0] sz;
        logic [15:0] cnt;
        logic [63:0] med;
        logic [12:0] acc;
        logic        done;
    } t_acc_result;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [31:0]  i_cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;   // disp_x, disp_y, disp_z, vertex_index, 4'b0
    logic [2:0]   s_tuser = '0;   // op[1:0], non_finite
    logic         s_tlast = 1'b0; // last_element
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [239:0] m_tdata;        // sum_x, sum_y, sum_z, contrib_count,
                                  // median_length_sq, accepted_count, 3'b0
    logic         m_tuser;        // done_res

    median_gated_gradient_accumulator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // model state
    logic [31:0]        gain_q;
    t_vec_item          batch_q[$];
    logic signed [47:0] fsum_x [NUM_VERT];
    logic signed [47:0] fsum_y [NUM_VERT];
    logic signed [47:0] fsum_z [NUM_VERT];
    logic [15:0]        fcnt   [NUM_VERT];
    logic [63:0]        last_med;
    logic [12:0]        last_acc;

    t_acc_result pending_results[$];
    int errors = 0;
    int cycles = 0;
    int n_loads = 0, n_batches = 0, n_reads = 0, n_clears = 0, n_gains = 0;

    initial forever #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("median_gated_gradient_accumulator_test NOT OK");
            $finish;
        end
    end

    function automatic logic [63:0] len_sq(logic signed [31:0] x, logic signed [31:0] y,
                                           logic signed [31:0] z);
        logic signed [63:0] a, b, c;
        a = 64'(x) * 64'(x);
        b = 64'(y) * 64'(y);
        c = 64'(z) * 64'(z);
        return a + b + c;
    endfunction

    // -(v * gain) in Q24.40, rounded half up to Q32.16
    function automatic logic signed [47:0] step_of(logic signed [31:0] v);
        logic signed [65:0] p;
        p = -($signed({{34{v[31]}}, v}) * $signed({34'b0, gain_q}));
        p = (p + 66'sd8388608) >>> 24;
        return p[47:0];
    endfunction

    function automatic logic signed [47:0] sat_add(logic signed [47:0] s,
                                                   logic signed [47:0] d);
        logic signed [49:0] r;
        r = {{2{s[47]}}, s} + {{2{d[47]}}, d};
        if (r > 50'sh7FFFFFFFFFFF) return 48'sh7FFFFFFFFFFF;
        if (r < -50'sh800000000000) return 48'sh800000000000;
        return r[47:0];
    endfunction

    function automatic void clear_model();
        for (int i = 0; i < NUM_VERT; i++) begin
            fsum_x[i] = '0; fsum_y[i] = '0; fsum_z[i] = '0; fcnt[i] = '0;
        end
    endfunction

    function automatic void finish_batch();
        logic [63:0] lens[$];
        logic [63:0] med, l;
        int          acc;
        t_vec_item   e;
        med = '0;
        acc = 0;
        foreach (batch_q[i]) begin
            l = len_sq(batch_q[i].x, batch_q[i].y, batch_q[i].z);
            if (!batch_q[i].nf && l != 0) lens = {lens, l};
        end
        lens.sort();
        if (lens.size() > 0) med = lens[lens.size() / 2];
        foreach (batch_q[i]) begin
            e = batch_q[i];
            l = len_sq(e.x, e.y, e.z);
            if (!e.nf && (l / 64'd2500) < med) begin
                acc++;
                fsum_x[e.vi] = sat_add(fsum_x[e.vi], step_of(e.x));
                fsum_y[e.vi] = sat_add(fsum_y[e.vi], step_of(e.y));
                fsum_z[e.vi] = sat_add(fsum_z[e.vi], step_of(e.z));
                if ((e.x | e.y | e.z) != 0 && fcnt[e.vi] != 16'hFFFF) fcnt[e.vi]++;
            end
        end
        last_med = med;
        last_acc = (acc > 8191) ? 13'h1FFF : 13'(acc);
        batch_q.delete();
    endfunction

    function automatic t_acc_result predict_result(t_vec_item it);
        t_acc_result r;
        r = '{default: '0};
        case (it.op)
            mgga_pkg::OP_CLEAR: begin
                clear_model();
                r.done = 1'b1;
                n_clears++;
            end
            mgga_pkg::OP_LOAD: begin
                if (batch_q.size() < NUM_ELEM) batch_q = {batch_q, it};
                n_loads++;
                if (it.last) begin
                    finish_batch();
                    r.done = 1'b1;
                    n_batches++;
                end
            end
            mgga_pkg::OP_READ: begin
                r.sx = fsum_x[it.vi]; r.sy = fsum_y[it.vi]; r.sz = fsum_z[it.vi];
                r.cnt = fcnt[it.vi];
                n_reads++;
            end
            default: return r;
        endcase
        r.med = last_med;
        r.acc = last_acc;
        return r;
    endfunction

    task automatic cmp(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            $error("%s: expected %h, got %h", name, e, a);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_acc_result e;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
            end else begin
                e = pending_results.pop_front();
                cmp("sum_x", e.sx, m_tdata[47:0]);
                cmp("sum_y", e.sy, m_tdata[95:48]);
                cmp("sum_z", e.sz, m_tdata[143:96]);
                cmp("contrib_count", e.cnt, m_tdata[159:144]);
                cmp("median_length_sq", e.med, m_tdata[223:160]);
                cmp("accepted_count", e.acc, m_tdata[236:224]);
                cmp("done_res", e.done, m_tuser);
            end
        end
    end

    // receiver: long ready runs, short stalls, an occasional long stall
    initial begin
        int n;
        forever begin
            if ($urandom_range(0, 9) < 6) begin
                n = $urandom_range(1, 20);
                repeat (n) begin @(negedge i_clk); m_tready <= 1'b1; end
            end else begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                 : $urandom_range(1, 3);
                repeat (n) begin @(negedge i_clk); m_tready <= 1'b0; end
            end
        end
    end

    task automatic send_item(t_vec_item it);
        int g;
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, it.vi, it.z, it.y, it.x};
        s_tuser  <= {it.nf, it.op};
        s_tlast  <= it.last;
        do @(posedge i_clk); while (!s_tready);
        pending_results = {pending_results, predict_result(it)};
        g = 0;
        if ($urandom_range(0, 3) == 0)
            g = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
        if (g > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    function automatic t_vec_item mk(logic [1:0] op, logic signed [31:0] x,
                                     logic signed [31:0] y, logic signed [31:0] z,
                                     logic nf, logic [11:0] vi, logic last);
        t_vec_item it;
        it.op = op; it.x = x; it.y = y; it.z = z; it.nf = nf; it.vi = vi; it.last = last;
        return it;
    endfunction

    task automatic wait_idle();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic set_gain(logic [31:0] g);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= g;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        gain_q = g;
        n_gains++;
    endtask

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(0, 9))
            0:       return 32'sd0;
            1:       return $urandom();
            2:       return $signed($urandom_range(0, 32'h00FF_FFFF)) << 7;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    function automatic logic [11:0] rand_vertex();
        return ($urandom_range(0, 7) == 0) ? 12'($urandom()) : 12'($urandom_range(0, 7));
    endfunction

    task automatic test_reset_state();
        send_item(mk(mgga_pkg::OP_READ, 0, 0, 0, 0, 12'd0, 0));
        send_item(mk(mgga_pkg::OP_READ, 0, 0, 0, 0, 12'hFFF, 0));
        send_item(mk(OP_NOP, '1, '1, '1, 1, 12'hFFF, 1));
    endtask

    task automatic test_directed();
        // extremes of the x and y components, one outlier rejected by the gate
        send_item(mk(mgga_pkg::OP_LOAD, 32'sh7FFFFFFF, 32'sh80000000, 32'sh00010000, 0,
                     12'hFFF, 0));
        send_item(mk(mgga_pkg::OP_LOAD, 32'sh00010000, 32'sh00010000, 0, 0, 12'd1, 0));
        send_item(mk(mgga_pkg::OP_LOAD, -32'sh00010000, 0, 32'sh00020000, 0, 12'd1, 0));
        send_item(mk(mgga_pkg::OP_LOAD, 0, 0, 0, 0, 12'd2, 0));
        send_item(mk(mgga_pkg::OP_LOAD, 32'sh00030000, 0, 0, 1, 12'd1, 1));
        send_item(mk(mgga_pkg::OP_READ, 0, 0, 0, 0, 12'd1, 0));
        send_item(mk(mgga_pkg::OP_READ, 0, 0, 0, 0, 12'd2, 0));
        send_item(mk(mgga_pkg::OP_READ, 0, 0, 0, 0, 12'hFFF, 0));
        // empty median set: all zero or non-finite
        send_item(mk(mgga_pkg::OP_LOAD, 0, 0, 0, 0, 12'd3, 0));
        send_item(mk(mgga_pkg::OP_LOAD, 32'sh00010000, 0, 0, 1, 12'd3, 1));
        send_item(mk(mgga_pkg::OP_READ, 0, 0, 0, 0, 12'd3, 0));
        // clear in the middle of a batch keeps the loaded part
        send_item(mk(mgga_pkg::OP_LOAD, 32'sh00008000, 32'sh00008000, 0, 0, 12'd4, 0));
        send_item(mk(mgga_pkg::OP_CLEAR, 0, 0, 0, 0, 12'd0, 0));
        send_item(mk(mgga_pkg::OP_READ, 0, 0, 0, 0, 12'd1, 0));
        send_item(mk(mgga_pkg::OP_LOAD, 32'sh00004000, 0, 32'sh00004000, 0, 12'd4, 1));
        send_item(mk(mgga_pkg::OP_READ, 0, 0, 0, 0, 12'd4, 0));
        send_item(mk(OP_NOP, 0, 0, 0, 0, 12'd4, 0));
        // single-item batch
        send_item(mk(mgga_pkg::OP_LOAD, -32'sh00001000, 32'sh7FFFFFFF, -32'sh1, 0, 12'd5, 1));
        send_item(mk(mgga_pkg::OP_READ, 0, 0, 0, 0, 12'd5, 0));
    endtask

    task automatic test_random(int budget);
        int sent, n;
        sent = 0;
        while (sent < budget) begin
            case ($urandom_range(0, 19))
                0: begin
                    send_item(mk(mgga_pkg::OP_CLEAR, $urandom(), $urandom(), $urandom(),
                                 1'($urandom()), 12'($urandom()), 1'($urandom())));
                    sent++;
                end
                1: send_item(mk(OP_NOP, $urandom(), $urandom(), $urandom(),
                                1'($urandom()), 12'($urandom()), 1'($urandom())));
                2, 3, 4, 5: begin
                    send_item(mk(mgga_pkg::OP_READ, $urandom(), $urandom(), $urandom(),
                                 1'($urandom()), rand_vertex(), 1'($urandom())));
                    sent++;
                end
                default: begin
                    n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 12);
                    for (int i = 0; i < n; i++)
                        send_item(mk(mgga_pkg::OP_LOAD, rand_comp(), rand_comp(), rand_comp(),
                                     1'($urandom_range(0, 9) == 0), rand_vertex(),
                                     i == n - 1));
                    sent += n;
                end
            endcase
        end
    endtask

    initial begin
        logic [31:0] gains[5];
        gain_q   = mgga_pkg::GAIN_RESET;
        last_med = '0;
        last_acc = '0;
        clear_model();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_directed();
        set_gain(32'hFFFF_FFFF);
        test_directed();

        gains[0] = mgga_pkg::GAIN_RESET;
        gains[1] = 32'hFFFF_FFFF;
        gains[2] = 32'h0;
        gains[3] = $urandom();
        gains[4] = $urandom_range(1, 32'h00FF_FFFF);
        foreach (gains[k]) begin
            set_gain(gains[k]);
            test_random(370);
        end

        wait_idle();
        repeat (300) @(posedge i_clk);
        $display("covered %0d loads in %0d batches, %0d reads, %0d clears, %0d gain settings",
                 n_loads, n_batches, n_reads, n_clears, n_gains);
        if (errors == 0 && pending_results.size() == 0)
            $display("median_gated_gradient_accumulator_test OK");
        else
            $display("median_gated_gradient_accumulator_test NOT OK");
        $finish;
    end

endmodule
